[hw/rtl/srrc_pkg.sv]
// ============================================================================
// srrc_pkg : symbol rate register calculator package
// Field widths, rate limits, band table and clock-loop words.
// ============================================================================
package srrc_pkg;

    // field widths
    localparam int RATE_W  = 26;
    localparam int CLK_W   = 28;
    localparam int DIV_W   = 24;   // master clock >> 4
    localparam int RATIO_W = 24;
    localparam int WORD_W  = 8;
    localparam int FRAC_W  = 20;   // ratio scale 2^20

    // stream widths (packed to whole bytes)
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 40;

    // register reset and divider default
    localparam logic [CLK_W-1:0] CLK_RESET          = 28'd88000000;
    localparam int               DEF_BITS_PER_STAGE = 4;

    // legal rate window
    localparam logic [RATE_W-1:0] RATE_MIN = 26'd1000000;
    localparam logic [RATE_W-1:0] RATE_MAX = 26'd45000000;

    // band upper limits
    localparam logic [RATE_W-1:0] BAND_0_MAX = 26'd1500000;
    localparam logic [RATE_W-1:0] BAND_1_MAX = 26'd3000000;
    localparam logic [RATE_W-1:0] BAND_2_MAX = 26'd7000000;
    localparam logic [RATE_W-1:0] BAND_3_MAX = 26'd14000000;
    localparam logic [RATE_W-1:0] BAND_4_MAX = 26'd30000000;

    // clock-loop words
    localparam logic [WORD_W-1:0] LOOP_A_LOW  = 8'hb7;
    localparam logic [WORD_W-1:0] LOOP_A_MID  = 8'hb6;
    localparam logic [WORD_W-1:0] LOOP_A_HIGH = 8'hb4;
    localparam logic [WORD_W-1:0] LOOP_B_0    = 8'h47;
    localparam logic [WORD_W-1:0] LOOP_B_1    = 8'h4b;
    localparam logic [WORD_W-1:0] LOOP_B_2    = 8'h4f;
    localparam logic [WORD_W-1:0] LOOP_B_3    = 8'h53;
    localparam logic [WORD_W-1:0] LOOP_B_5    = 8'h51;

    localparam logic [RATIO_W-1:0] RATIO_MASK = 24'hfffff0;

    // clock-loop words for a rate: {word_a, word_b}
    function automatic logic [2*WORD_W-1:0] loop_words(input logic [RATE_W-1:0] rate);
        logic [2*WORD_W-1:0] w;
        priority if (rate <= BAND_0_MAX) begin
            w = {LOOP_A_LOW, LOOP_B_0};
        end else if (rate <= BAND_1_MAX) begin
            w = {LOOP_A_LOW, LOOP_B_1};
        end else if (rate <= BAND_2_MAX) begin
            w = {LOOP_A_LOW, LOOP_B_2};
        end else if (rate <= BAND_3_MAX) begin
            w = {LOOP_A_LOW, LOOP_B_3};
        end else if (rate <= BAND_4_MAX) begin
            w = {LOOP_A_MID, LOOP_B_3};
        end else begin
            w = {LOOP_A_HIGH, LOOP_B_5};
        end
        return w;
    endfunction

endpackage

[hw/rtl/symbol_rate_register_calc_top.sv]
// ============================================================================
// symbol_rate_register_calc_top : symbol rate programming word calculator
// Pipelined restoring divider for floor(rate * 2^20 / (mclk >> 4)) plus
// band lookup of the clock-loop words A and B.
// ============================================================================
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+---------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready| tdata: req_rate
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready| tuser: invalid, tdata: words
//  cfg       | in  | i_cfg_we                         | i_cfg_wdata: master_clock_hz
//
//  One request per cycle sustained while the output is not stalled. A result is
//  offered once its request has registered into the input stage and then
//  passed NS divider stages, NS = ceil(46 / P_BITS_PER_STAGE), with four
//  quotient bits per stage by default, each stage a chain of compare/subtract
//  steps on a 24-bit remainder.
//  Reset clears the valid bits and loads the clock register with 88 MHz.
//  A stall at the output freezes the whole pipeline, empty stages included,
//  so the input is held off only while the last stage waits.
//
module symbol_rate_register_calc_top
    import srrc_pkg::*;
#(
    parameter int P_BITS_PER_STAGE = DEF_BITS_PER_STAGE   // 1..8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CLK_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,   // [25:0] req_rate
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,   // [7:0] loop_word_a,
                                                    // [15:8] loop_word_b,
                                                    // [39:16] timing_ratio
    output logic                  o_m_axis_tuser    // [0] invalid
);

    localparam int DVD_BITS = RATE_W + FRAC_W;
    localparam int NS       = (DVD_BITS + P_BITS_PER_STAGE - 1) / P_BITS_PER_STAGE;
    localparam int DW       = NS * P_BITS_PER_STAGE;

    typedef struct packed {
        logic                inv;
        logic [WORD_W-1:0]   word_a;
        logic [WORD_W-1:0]   word_b;
        logic [DIV_W-1:0]    rem;
        logic [DW-1:0]       dvd;
        logic [RATIO_W-1:0]  quo;
    } t_stage;

    logic [CLK_W-1:0]  r_clk;
    logic [DIV_W-1:0]  w_div;
    logic              r_vld [0:NS];
    t_stage            r_st  [0:NS];
    t_stage            n_st  [0:NS];
    logic              w_adv;
    logic [RATE_W-1:0] w_rate;
    logic              w_inv;
    logic [2*WORD_W-1:0] w_words;

    // clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clk <= CLK_RESET;
        end else if (i_cfg_we) begin
            r_clk <= i_cfg_wdata;
        end
    end

    assign w_div = r_clk[CLK_W-1:CLK_W-DIV_W];

    // pipeline moves whenever the output slot is free or being drained
    assign w_adv           = !r_vld[NS] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    // input stage: range check, band words, dividend = rate << 20
    assign w_rate  = i_s_axis_tdata[RATE_W-1:0];
    assign w_inv   = (w_rate < RATE_MIN) || (w_rate > RATE_MAX);
    assign w_words = loop_words(w_rate);

    // input stage next value, then P_BITS_PER_STAGE restoring steps per divider stage
    always_comb begin
        logic [DIV_W-1:0]   rem;
        logic [DW-1:0]      dvd;
        logic [RATIO_W-1:0] quo;
        logic [DIV_W:0]     trial;
        n_st[0].inv    = w_inv;
        n_st[0].word_a = w_inv ? '0 : w_words[2*WORD_W-1:WORD_W];
        n_st[0].word_b = w_inv ? '0 : w_words[WORD_W-1:0];
        n_st[0].rem    = '0;
        n_st[0].dvd    = DW'({w_rate, {FRAC_W{1'b0}}});
        n_st[0].quo    = '0;
        for (int s = 0; s < NS; s++) begin
            n_st[s+1] = r_st[s];
            rem = r_st[s].rem;
            dvd = r_st[s].dvd;
            quo = r_st[s].quo;
            for (int k = 0; k < P_BITS_PER_STAGE; k++) begin
                trial = {rem, dvd[DW-1]};
                dvd   = {dvd[DW-2:0], 1'b0};
                if (trial >= {1'b0, w_div}) begin
                    // zero divisor always lands here, giving all-ones
                    trial = trial - {1'b0, w_div};
                    rem   = trial[DIV_W-1:0];
                    quo   = {quo[RATIO_W-2:0], 1'b1};
                end else begin
                    rem   = trial[DIV_W-1:0];
                    quo   = {quo[RATIO_W-2:0], 1'b0};
                end
            end
            n_st[s+1].rem = rem;
            n_st[s+1].dvd = dvd;
            n_st[s+1].quo = quo;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= NS; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int s = 0; s < NS; s++) begin
                r_vld[s+1] <= r_vld[s];
            end
        end
    end

    // stage payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s <= NS; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // result
    assign o_m_axis_tvalid = r_vld[NS];
    assign o_m_axis_tuser  = r_st[NS].inv;
    assign o_m_axis_tdata  = {(r_st[NS].inv ? RATIO_W'(0) : (r_st[NS].quo & RATIO_MASK)),
                              r_st[NS].word_b, r_st[NS].word_a};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // input held off only by a full, stalled output slot
    a_ready_only_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> (o_m_axis_tvalid && !i_m_axis_tready))
        else $error("input stalled without an output stall");

    // out-of-band rate gives an all-zero word set
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser) |-> (o_m_axis_tdata == '0))
        else $error("invalid result carries nonzero words");

    // zero divisor saturates the ratio
    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser && (w_div == '0))
        |-> (o_m_axis_tdata[M_TDATA_W-1:2*WORD_W] == RATIO_MASK))
        else $error("zero divisor did not saturate ratio");

    // a valid rate always maps to a loop word A from the band table
    a_band_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser)
        |-> (o_m_axis_tdata[WORD_W-1:0] == LOOP_A_LOW
             || o_m_axis_tdata[WORD_W-1:0] == LOOP_A_MID
             || o_m_axis_tdata[WORD_W-1:0] == LOOP_A_HIGH))
        else $error("loop word A outside band table");

endmodule

[bench/symbol_rate_register_calc_top_tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// symbol_rate_register_calc_top_tb : bench for the symbol rate calculator
// A table of edge-case requests runs first, then random rates under several
// master clock settings. Every result is checked field by field against a
// pinned value or a local calculation of the band words and timing ratio, with
// random gaps on the request side and random stalls on the result side.
// ============================================================================
module symbol_rate_register_calc_top_tb;
    import srrc_pkg::*;

    localparam int PIPE_LATENCY   = 13;     // input stage + divider stages
    localparam int QUIET_LIMIT    = 3000;   // cycles with no transfer at all
    localparam int PHASES         = 8;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_CYCLES    = 250;
    localparam int DIR_ROWS       = 29;

    // one result, as the block should report it
    typedef struct packed {
        logic                invalid;
        logic [WORD_W-1:0]   word_a;
        logic [WORD_W-1:0]   word_b;
        logic [RATIO_W-1:0]  ratio;
    } t_rate_words;

    typedef enum logic {ROW_REQUEST, ROW_CLOCK} t_row_kind;

    // directed row: a request (optionally with typed result) or a clock write
    typedef struct packed {
        t_row_kind     kind;
        logic [CLK_W-1:0] value;
        logic          pinned;
        t_rate_words   words;
    } t_dir_row;

    typedef enum logic [1:0] {RX_STREAM, RX_COIN, RX_SPARSE, RX_PATTERN} t_rx_mode;

    function automatic t_dir_row plain_req(input int unsigned rate);
        return '{ROW_REQUEST, CLK_W'(rate), 1'b0, t_rate_words'(0)};
    endfunction

    function automatic t_dir_row pinned_req(input int unsigned rate, input logic inv,
                                            input logic [7:0] a, input logic [7:0] b,
                                            input logic [23:0] ratio);
        return '{ROW_REQUEST, CLK_W'(rate), 1'b1, '{inv, a, b, ratio}};
    endfunction

    function automatic t_dir_row clock_row(input logic [CLK_W-1:0] mclk);
        return '{ROW_CLOCK, mclk, 1'b0, t_rate_words'(0)};
    endfunction

    // band edges at the reset clock, then divisor-zero and clock extremes
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        pinned_req(0,        1'b1, 8'h00, 8'h00, 24'h000000),
        pinned_req(999999,   1'b1, 8'h00, 8'h00, 24'h000000),
        plain_req(1000000),
        plain_req(1500000),
        plain_req(1500001),
        plain_req(3000000),
        plain_req(3000001),
        plain_req(7000000),
        plain_req(7000001),
        plain_req(14000000),
        plain_req(14000001),
        plain_req(30000000),
        plain_req(30000001),
        plain_req(45000000),
        pinned_req(45000001, 1'b1, 8'h00, 8'h00, 24'h000000),
        pinned_req(67108863, 1'b1, 8'h00, 8'h00, 24'h000000),
        clock_row(28'd0),
        pinned_req(1000000,  1'b0, 8'hb7, 8'h47, 24'hfffff0),
        pinned_req(45000000, 1'b0, 8'hb4, 8'h51, 24'hfffff0),
        pinned_req(50000000, 1'b1, 8'h00, 8'h00, 24'h000000),
        clock_row(28'd15),
        pinned_req(20000000, 1'b0, 8'hb6, 8'h53, 24'hfffff0),
        clock_row(28'd16),
        plain_req(45000000),
        clock_row(28'd200000000),
        plain_req(1000000),
        plain_req(45000000),
        clock_row(28'hfffffff),
        plain_req(30000000)
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CLK_W-1:0]      i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [S_TDATA_W-1:0]  i_s_axis_tdata = '0;   // [25:0] req_rate
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_axis_tdata;        // [7:0] loop_word_a, [15:8] loop_word_b,
                                                  // [39:16] timing_ratio
    logic                  o_m_axis_tuser;        // [0] invalid

    t_rate_words       offered_words = '0;   // result due for the request on the bus
    t_rate_words       pending_words [$];
    logic [CLK_W-1:0]  mclk_setting = CLK_RESET;
    int                fail_count = 0;
    int                burst_left = 0;

    symbol_rate_register_calc_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #2 i_clk = ~i_clk;

    // band words and timing ratio for one rate at a given master clock
    function automatic t_rate_words calc_words(input logic [RATE_W-1:0] rate,
                                               input logic [CLK_W-1:0] mclk);
        t_rate_words      w;
        logic [DIV_W-1:0] divisor;
        logic [63:0]      quot;
        w = '0;
        divisor = mclk[CLK_W-1:4];
        if (rate < RATE_MIN || rate > RATE_MAX) begin
            w.invalid = 1'b1;
            return w;
        end
        if (rate <= BAND_0_MAX) begin
            w.word_a = LOOP_A_LOW;  w.word_b = LOOP_B_0;
        end else if (rate <= BAND_1_MAX) begin
            w.word_a = LOOP_A_LOW;  w.word_b = LOOP_B_1;
        end else if (rate <= BAND_2_MAX) begin
            w.word_a = LOOP_A_LOW;  w.word_b = LOOP_B_2;
        end else if (rate <= BAND_3_MAX) begin
            w.word_a = LOOP_A_LOW;  w.word_b = LOOP_B_3;
        end else if (rate <= BAND_4_MAX) begin
            w.word_a = LOOP_A_MID;  w.word_b = LOOP_B_3;
        end else begin
            w.word_a = LOOP_A_HIGH; w.word_b = LOOP_B_5;
        end
        // zero divisor saturates; otherwise keep low 24 bits, clear nibble
        if (divisor == '0) begin
            w.ratio = RATIO_MASK;
        end else begin
            quot = {38'd0, rate} << FRAC_W;
            quot = quot / divisor;
            w.ratio = quot[RATIO_W-1:0] & RATIO_MASK;
        end
        return w;
    endfunction

    // mostly in-band rates, weighted toward band limits; some full-range noise
    function automatic logic [RATE_W-1:0] pick_rate();
        int unsigned       sel;
        logic [RATE_W-1:0] band_limit;
        sel = $urandom_range(0, 99);
        if (sel < 50) begin
            return RATE_W'($urandom_range(RATE_MIN, RATE_MAX));
        end else if (sel < 70) begin
            case ($urandom_range(0, 6))
                0: band_limit = RATE_MIN;
                1: band_limit = BAND_0_MAX;
                2: band_limit = BAND_1_MAX;
                3: band_limit = BAND_2_MAX;
                4: band_limit = BAND_3_MAX;
                5: band_limit = BAND_4_MAX;
                default: band_limit = RATE_MAX;
            endcase
            return RATE_W'(int'(band_limit) + int'($urandom_range(0, 8)) - 4);
        end else if (sel < 85) begin
            return RATE_W'($urandom_range(RATE_MIN, BAND_1_MAX));
        end
        return RATE_W'($urandom);
    endfunction

    task automatic report_mismatch(input string field, input logic [39:0] got,
                                   input logic [39:0] want);
        fail_count++;
        $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, field, got, want);
    endtask

    // offer one request; bursts of random length with random gaps between
    task automatic offer_rate(input logic [RATE_W-1:0] rate, input t_rate_words words);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {{(S_TDATA_W-RATE_W){1'b0}}, rate};
        offered_words   <= words;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (pending_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_clock(input logic [CLK_W-1:0] mclk);
        drain_results();
        i_cfg_we     <= 1'b1;
        i_cfg_wdata  <= mclk;
        mclk_setting = mclk;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
    endtask

    // request/result tracking and field compare
    always @(posedge i_clk) begin
        t_rate_words want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                pending_words.push_back(offered_words);
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_words.size() == 0) begin
                    report_mismatch("unrequested result", o_m_axis_tdata, '0);
                end else begin
                    want = pending_words.pop_front();
                    if (o_m_axis_tuser !== want.invalid)
                        report_mismatch("invalid", 40'(o_m_axis_tuser),
                                        40'(want.invalid));
                    if (o_m_axis_tdata[7:0] !== want.word_a)
                        report_mismatch("loop_word_a", 40'(o_m_axis_tdata[7:0]),
                                        40'(want.word_a));
                    if (o_m_axis_tdata[15:8] !== want.word_b)
                        report_mismatch("loop_word_b", 40'(o_m_axis_tdata[15:8]),
                                        40'(want.word_b));
                    if (o_m_axis_tdata[39:16] !== want.ratio)
                        report_mismatch("timing_ratio", 40'(o_m_axis_tdata[39:16]),
                                        40'(want.ratio));
                end
            end
        end
    end

    // result side: changing stall patterns, plus long hold-offs to back up the pipe
    int          results_taken = 0;
    int          next_hold_at = 300;
    int          hold_left = 0;
    int          mode_left = 0;
    t_rx_mode    stall_mode = RX_STREAM;
    logic [7:0]  stall_mask = 8'hff;
    logic [2:0]  pattern_pos = '0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                results_taken++;
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else if (results_taken >= next_hold_at) begin
                hold_left = HOLD_CYCLES;
                next_hold_at += 600;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = t_rx_mode'($urandom_range(0, 3));
                    mode_left  = $urandom_range(20, 80);
                    stall_mask = 8'($urandom);
                end
                mode_left--;
                pattern_pos++;
                case (stall_mode)
                    RX_STREAM:  i_m_axis_tready <= 1'b1;
                    RX_COIN:    i_m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN: i_m_axis_tready <= stall_mask[pattern_pos];
                endcase
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                     || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // main sequence
    initial begin
        logic [CLK_W-1:0]  mclk;
        logic [RATE_W-1:0] rate;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, starting from the reset clock value
        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TABLE[k].kind == ROW_CLOCK) begin
                write_clock(DIR_TABLE[k].value);
            end else begin
                rate = DIR_TABLE[k].value[RATE_W-1:0];
                offer_rate(rate, DIR_TABLE[k].pinned ? DIR_TABLE[k].words
                                                     : calc_words(rate, mclk_setting));
            end
        end

        // random phases, one clock setting each
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: mclk = 28'd1000000;
                1: mclk = 28'd200000000;
                3: mclk = 28'hfffffff;
                4: mclk = CLK_W'($urandom_range(0, 4095));
                6: mclk = CLK_W'($urandom);
                7: mclk = CLK_RESET;
                default: mclk = CLK_W'($urandom_range(1000000, 200000000));
            endcase
            write_clock(mclk);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                rate = pick_rate();
                offer_rate(rate, calc_words(rate, mclk_setting));
            end
        end

        drain_results();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/srrc_pkg.sv
hw/rtl/symbol_rate_register_calc_top.sv
bench/symbol_rate_register_calc_top_tb.sv
